// ===== sv/swerve_wheel_kinematics_macros.svh =====
// Assertion macros used by the checker file swk_checker.sv
`ifndef SWERVE_WHEEL_KINEMATICS_MACROS_SVH
`define SWERVE_WHEEL_KINEMATICS_MACROS_SVH
// antecedent implies consequent in the same cycle
`define SWK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define SWK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/swk_pkg.sv =====
`default_nettype none
package swk_pkg;

    localparam int SUM_W            = 20;  // wheel vector component, Q8.12
    localparam int SQ_W             = 40;  // sum of squares
    localparam int ROOT_W           = 20;  // wheel speed
    localparam int DIV_W            = 36;  // dividend width of the shared divider
    localparam int DVS_W            = 20;  // divisor width
    localparam int CX_W             = 31;  // CORDIC x/y datapath
    localparam int Z_W              = 21;  // CORDIC angle accumulator, 2^-16 rad
    localparam int CFG_WHEELS       = 3;
    localparam int MAX_WHEELS       = 4;
    localparam int NUM_WHEELS_DEF   = 3;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int PI_Q16           = 205887;
    localparam int PI_Q13           = 25736;
    localparam int Q_ROUND          = 2048;
    localparam int CMD_MAX          = 65535;

    typedef enum logic [2:0] {
        REG_W0X, REG_W0Y, REG_W1X, REG_W1Y, REG_W2X, REG_W2Y, REG_MAX_SPEED, REG_FULL_SCALE
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_WHEELS-1:0][15:0] pos_x;
        logic [CFG_WHEELS-1:0][15:0] pos_y;
        logic [14:0]                 max_speed;
        logic [15:0]                 full_scale;
    } t_cfg;

    // one command after the front end: unscaled wheel vectors and the fastest speed
    typedef struct packed {
        logic [MAX_WHEELS-1:0][SUM_W-1:0] sx;
        logic [MAX_WHEELS-1:0][SUM_W-1:0] sy;
        logic [ROOT_W-1:0]                fastest;
    } t_item;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_SUM, F_SQ, F_SQRT_ST, F_SQRT, F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE, B_LOAD, B_SMUL, B_SDIV_ST, B_SDIV, B_SQ, B_SQRT_ST, B_SQRT,
        B_CORD_INIT, B_CORD, B_CMUL, B_CDIV_ST, B_CDIV, B_OUT
    } t_back_state;

    // arctangent of 2^-i in units of 2^-16 rad
    function automatic logic [16:0] atan_q16(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30385;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/swerve_wheel_kinematics.sv =====
// Front end and back end each handle one wheel at a time; the back end spends longer on each
// wheel when the command is scaled down to the speed limit. Command throughput is set by
// the back end's shared 36-step divider and 20-step square root; the two-entry queue lets the
// front end take the next command meanwhile. Synchronous active-low reset clears control
// state and loads register defaults (positions 0, max speed 4096, full scale 1000).
`default_nettype none
module swerve_wheel_kinematics #(
    parameter int NUM_WHEELS   = swk_pkg::NUM_WHEELS_DEF,
    parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // vel_x[15:0], vel_y[31:16], yaw_rate[47:32]
    // wheel result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // steer_angle[15:0], speed_command[31:16],
                                             // was_scaled[32], zero fill[39:33]
    output logic [1:0]       m_axis_tuser,   // wheel_index[1:0]
    output logic             m_axis_tlast    // last_wheel
);
    swk_pkg::t_cfg   r_cfg;
    swk_pkg::t_item  r_q [2];
    logic            r_wr_ptr, r_rd_ptr;
    logic [1:0]      r_count;

    logic            push, pop, full, empty;
    swk_pkg::t_item  push_item;
    swk_pkg::t_reg_idx ridx;
    logic [15:0]     angle, cmd;
    logic            scaled;

    assign ridx = swk_pkg::t_reg_idx'(paddr[4:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x      <= '0;
            r_cfg.pos_y      <= '0;
            r_cfg.max_speed  <= 15'd4096;
            r_cfg.full_scale <= 16'd1000;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                swk_pkg::REG_W0X:        r_cfg.pos_x[0]   <= pwdata[15:0];
                swk_pkg::REG_W0Y:        r_cfg.pos_y[0]   <= pwdata[15:0];
                swk_pkg::REG_W1X:        r_cfg.pos_x[1]   <= pwdata[15:0];
                swk_pkg::REG_W1Y:        r_cfg.pos_y[1]   <= pwdata[15:0];
                swk_pkg::REG_W2X:        r_cfg.pos_x[2]   <= pwdata[15:0];
                swk_pkg::REG_W2Y:        r_cfg.pos_y[2]   <= pwdata[15:0];
                swk_pkg::REG_MAX_SPEED:  r_cfg.max_speed  <= pwdata[14:0];
                swk_pkg::REG_FULL_SCALE: r_cfg.full_scale <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (ridx)
            swk_pkg::REG_W0X:        prdata = 32'(r_cfg.pos_x[0]);
            swk_pkg::REG_W0Y:        prdata = 32'(r_cfg.pos_y[0]);
            swk_pkg::REG_W1X:        prdata = 32'(r_cfg.pos_x[1]);
            swk_pkg::REG_W1Y:        prdata = 32'(r_cfg.pos_y[1]);
            swk_pkg::REG_W2X:        prdata = 32'(r_cfg.pos_x[2]);
            swk_pkg::REG_W2Y:        prdata = 32'(r_cfg.pos_y[2]);
            swk_pkg::REG_MAX_SPEED:  prdata = 32'(r_cfg.max_speed);
            swk_pkg::REG_FULL_SCALE: prdata = 32'(r_cfg.full_scale);
            default:                 prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    swk_front #(.NUM_WHEELS(NUM_WHEELS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_vel_x    (s_axis_tdata[15:0]),
        .i_vel_y    (s_axis_tdata[31:16]),
        .i_yaw_rate (s_axis_tdata[47:32]),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_item     (push_item),
        .i_full     (full)
    );

    // two-entry queue between front and back
    assign full  = (r_count == 2'd2);
    assign empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_q[r_wr_ptr] <= push_item;
                r_wr_ptr      <= ~r_wr_ptr;
            end
            if (pop) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    swk_back #(.NUM_WHEELS(NUM_WHEELS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .o_pop           (pop),
        .i_item          (r_q[r_rd_ptr]),
        .i_cfg           (r_cfg),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_wheel_index   (m_axis_tuser),
        .o_steer_angle   (angle),
        .o_speed_command (cmd),
        .o_was_scaled    (scaled),
        .o_last_wheel    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, scaled, cmd, angle};
endmodule
`default_nettype wire

// ===== sv/swk_sqrt.sv =====
`default_nettype none
// Integer square root, two operand bits per cycle
module swk_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [swk_pkg::SQ_W-1:0]   i_op,
    output logic                            o_done,
    output logic [swk_pkg::ROOT_W-1:0]      o_root
);
    localparam int RW  = swk_pkg::ROOT_W;
    localparam int CW  = $clog2(RW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [swk_pkg::SQ_W-1:0] r_op;
    logic [RW+1:0]     r_rem;
    logic [RW-1:0]     r_root;

    logic [RW+3:0]     rem2;
    logic [RW+3:0]     trial;
    logic              ge;

    // one restoring step
    always_comb begin
        rem2  = {r_rem, r_op[swk_pkg::SQ_W-1 -: 2]};
        trial = (RW+4)'({r_root, 2'b01});
        ge    = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_op;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_op <= {r_op[swk_pkg::SQ_W-3:0], 2'b00};
                if (ge) begin
                    r_rem  <= (RW+2)'(rem2 - trial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem2[RW+1:0];
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== sv/swk_div.sv =====
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle
module swk_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [swk_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [swk_pkg::DVS_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [swk_pkg::DIV_W-1:0]       o_quot
);
    localparam int NW = swk_pkg::DIV_W;
    localparam int DW = swk_pkg::DVS_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;

    logic [DW:0]   rem2;
    logic          ge;

    always_comb begin
        rem2 = {r_rem, r_q[NW-1]};
        ge   = (rem2 >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? DW'(rem2 - {1'b0, r_div}) : rem2[DW-1:0];
                r_q   <= {r_q[NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== sv/swk_front.sv =====
`default_nettype none
// Front end: forms every wheel vector of a command and finds the fastest wheel
module swk_front #(
    parameter int NUM_WHEELS = swk_pkg::NUM_WHEELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [15:0]   i_vel_x,
    input  wire logic [15:0]   i_vel_y,
    input  wire logic [15:0]   i_yaw_rate,
    input  wire swk_pkg::t_cfg i_cfg,
    output logic               o_push,
    output swk_pkg::t_item     o_item,
    input  wire logic          i_full
);
    localparam int SW = swk_pkg::SUM_W;

    swk_pkg::t_front_state r_state, n_state;
    logic [1:0]               r_w;
    logic signed [15:0]       r_vx, r_vy, r_yaw;
    logic signed [31:0]       r_prod_x, r_prod_y;
    logic signed [SW-1:0]     r_sx, r_sy;
    logic [swk_pkg::SQ_W-1:0] r_sqx, r_sqy;
    swk_pkg::t_item           r_item;

    logic                     sqrt_done;
    logic [swk_pkg::ROOT_W-1:0] sqrt_root;
    logic signed [15:0]       px, py;
    logic signed [33:0]       ty, tx, sum_x, sum_y;
    logic                     last_w;

    // wheel position, extra wheels sit at the centre
    always_comb begin
        if (r_w < 2'(swk_pkg::CFG_WHEELS)) begin
            px = i_cfg.pos_x[r_w];
            py = i_cfg.pos_y[r_w];
        end else begin
            px = '0;
            py = '0;
        end
        ty    = 34'sd2048 - 34'(r_prod_y);
        tx    = 34'(r_prod_x) + 34'sd2048;
        sum_x = 34'(r_vx) + (ty >>> 12);
        sum_y = 34'(r_vy) + (tx >>> 12);
        last_w = (r_w == 2'(NUM_WHEELS-1));
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            swk_pkg::F_IDLE:    if (i_valid) n_state = swk_pkg::F_MUL;
            swk_pkg::F_MUL:     n_state = swk_pkg::F_SUM;
            swk_pkg::F_SUM:     n_state = swk_pkg::F_SQ;
            swk_pkg::F_SQ:      n_state = swk_pkg::F_SQRT_ST;
            swk_pkg::F_SQRT_ST: n_state = swk_pkg::F_SQRT;
            swk_pkg::F_SQRT: begin
                if (sqrt_done) n_state = last_w ? swk_pkg::F_PUSH : swk_pkg::F_MUL;
            end
            swk_pkg::F_PUSH:    if (!i_full) n_state = swk_pkg::F_IDLE;
            default:            n_state = swk_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= swk_pkg::F_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            swk_pkg::F_IDLE: begin
                r_vx   <= i_vel_x;
                r_vy   <= i_vel_y;
                r_yaw  <= i_yaw_rate;
                r_w    <= '0;
                r_item <= '0;
            end
            swk_pkg::F_MUL: begin
                r_prod_x <= px * r_yaw;
                r_prod_y <= py * r_yaw;
            end
            swk_pkg::F_SUM: begin
                r_sx <= SW'(sum_x);
                r_sy <= SW'(sum_y);
                r_item.sx[r_w] <= SW'(sum_x);
                r_item.sy[r_w] <= SW'(sum_y);
            end
            swk_pkg::F_SQ: begin
                r_sqx <= swk_pkg::SQ_W'(r_sx * r_sx);
                r_sqy <= swk_pkg::SQ_W'(r_sy * r_sy);
            end
            swk_pkg::F_SQRT: begin
                if (sqrt_done) begin
                    if (sqrt_root > r_item.fastest) r_item.fastest <= sqrt_root;
                    r_w <= r_w + 1'b1;
                end
            end
            default: ;
        endcase
    end

    swk_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == swk_pkg::F_SQRT_ST),
        .i_op    (r_sqx + r_sqy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_ready = (r_state == swk_pkg::F_IDLE);
    assign o_push  = (r_state == swk_pkg::F_PUSH) && !i_full;
    assign o_item  = r_item;
endmodule
`default_nettype wire

// ===== sv/swk_back.sv =====
`default_nettype none
// Back end: per wheel scaling, speed, CORDIC heading and speed command
module swk_back #(
    parameter int NUM_WHEELS   = swk_pkg::NUM_WHEELS_DEF,
    parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    output logic                o_pop,
    input  wire swk_pkg::t_item i_item,
    input  wire swk_pkg::t_cfg  i_cfg,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [1:0]          o_wheel_index,
    output logic [15:0]         o_steer_angle,
    output logic [15:0]         o_speed_command,
    output logic                o_was_scaled,
    output logic                o_last_wheel
);
    localparam int SW  = swk_pkg::SUM_W;
    localparam int XW  = swk_pkg::CX_W;
    localparam int ZW  = swk_pkg::Z_W;
    localparam int NW  = swk_pkg::DIV_W;
    localparam int CNW = $clog2(CORDIC_STEPS);

    swk_pkg::t_back_state r_state, n_state;
    swk_pkg::t_item       r_item;
    logic [1:0]           r_w;
    logic                 r_scaled;
    logic                 r_comp;
    logic                 r_neg;
    logic signed [SW-1:0] r_sx, r_sy;
    logic [NW-1:0]        r_prod;
    logic [swk_pkg::SQ_W-1:0] r_sqx, r_sqy;
    logic [swk_pkg::ROOT_W-1:0] r_sp;
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic [CNW-1:0]       r_cnt;
    logic                 r_zero;
    logic [15:0]          r_cmd;
    logic                 r_out_valid;

    logic                 div_start, div_done, sqrt_done;
    logic [NW-1:0]        div_a, div_q;
    logic [swk_pkg::DVS_W-1:0] div_b;
    logic [swk_pkg::ROOT_W-1:0] sqrt_root;
    logic signed [SW-1:0] comp_v, q_signed;
    logic [SW-1:0]        comp_mag;
    logic signed [XW-1:0] x0, y0, ysh, xsh;
    logic signed [ZW-1:0] at, zr, ang;
    logic                 last_w, out_load;

    always_comb begin
        last_w   = (r_w == 2'(NUM_WHEELS-1));
        out_load = !r_out_valid || i_ready;
        comp_v   = r_comp ? r_sy : r_sx;
        comp_mag = comp_v[SW-1] ? SW'(-comp_v) : comp_v;
        q_signed = r_neg ? -$signed(div_q[SW-1:0]) : $signed(div_q[SW-1:0]);
        x0       = XW'(r_sx) <<< 8;
        y0       = XW'(r_sy) <<< 8;
        ysh      = r_cy >>> r_cnt;
        xsh      = r_cx >>> r_cnt;
        at       = ZW'(swk_pkg::atan_q16(5'(r_cnt)));
        // round to Q3.13 and clamp
        zr       = (r_cz + ZW'(4)) >>> 3;
        if (r_zero)                          ang = '0;
        else if (zr > ZW'(swk_pkg::PI_Q13))  ang = ZW'(swk_pkg::PI_Q13);
        else if (zr < -ZW'(swk_pkg::PI_Q13)) ang = -ZW'(swk_pkg::PI_Q13);
        else                                 ang = zr;
    end

    // shared divider operands
    always_comb begin
        div_start = (r_state == swk_pkg::B_SDIV_ST) || (r_state == swk_pkg::B_CDIV_ST);
        div_a     = r_prod;
        div_b     = (r_state == swk_pkg::B_SDIV_ST) ? r_item.fastest
                                                    : swk_pkg::DVS_W'(i_cfg.max_speed);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            swk_pkg::B_IDLE:      if (!i_empty) n_state = swk_pkg::B_LOAD;
            swk_pkg::B_LOAD:      n_state = r_scaled ? swk_pkg::B_SMUL : swk_pkg::B_SQ;
            swk_pkg::B_SMUL:      n_state = swk_pkg::B_SDIV_ST;
            swk_pkg::B_SDIV_ST:   n_state = swk_pkg::B_SDIV;
            swk_pkg::B_SDIV: begin
                if (div_done) n_state = r_comp ? swk_pkg::B_SQ : swk_pkg::B_SMUL;
            end
            swk_pkg::B_SQ:        n_state = swk_pkg::B_SQRT_ST;
            swk_pkg::B_SQRT_ST:   n_state = swk_pkg::B_SQRT;
            swk_pkg::B_SQRT:      if (sqrt_done) n_state = swk_pkg::B_CORD_INIT;
            swk_pkg::B_CORD_INIT: n_state = swk_pkg::B_CORD;
            swk_pkg::B_CORD: begin
                if (r_cnt == CNW'(CORDIC_STEPS-1)) n_state = swk_pkg::B_CMUL;
            end
            swk_pkg::B_CMUL: begin
                n_state = (i_cfg.max_speed == '0) ? swk_pkg::B_OUT : swk_pkg::B_CDIV_ST;
            end
            swk_pkg::B_CDIV_ST:   n_state = swk_pkg::B_CDIV;
            swk_pkg::B_CDIV:      if (div_done) n_state = swk_pkg::B_OUT;
            swk_pkg::B_OUT: begin
                if (out_load) n_state = last_w ? swk_pkg::B_IDLE : swk_pkg::B_LOAD;
            end
            default:              n_state = swk_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= swk_pkg::B_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            swk_pkg::B_IDLE: begin
                r_item   <= i_item;
                r_scaled <= (i_item.fastest > swk_pkg::ROOT_W'(i_cfg.max_speed));
                r_w      <= '0;
            end
            swk_pkg::B_LOAD: begin
                r_sx   <= r_item.sx[r_w];
                r_sy   <= r_item.sy[r_w];
                r_comp <= 1'b0;
            end
            swk_pkg::B_SMUL: begin
                r_neg  <= comp_v[SW-1];
                r_prod <= NW'(comp_mag * i_cfg.max_speed);
            end
            swk_pkg::B_SDIV: begin
                if (div_done) begin
                    if (r_comp) r_sy <= q_signed;
                    else        r_sx <= q_signed;
                    r_comp <= 1'b1;
                end
            end
            swk_pkg::B_SQ: begin
                r_sqx <= swk_pkg::SQ_W'(r_sx * r_sx);
                r_sqy <= swk_pkg::SQ_W'(r_sy * r_sy);
            end
            swk_pkg::B_SQRT: if (sqrt_done) r_sp <= sqrt_root;
            swk_pkg::B_CORD_INIT: begin
                r_zero <= (r_sx == '0) && (r_sy == '0);
                r_cnt  <= '0;
                // fold into the right half plane
                if (r_sx < 0) begin
                    r_cx <= -x0;
                    r_cy <= -y0;
                    r_cz <= (r_sy >= 0) ? ZW'(swk_pkg::PI_Q16) : -ZW'(swk_pkg::PI_Q16);
                end else begin
                    r_cx <= x0;
                    r_cy <= y0;
                    r_cz <= '0;
                end
            end
            swk_pkg::B_CORD: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + ysh;
                    r_cy <= r_cy - xsh;
                    r_cz <= r_cz + at;
                end else begin
                    r_cx <= r_cx - ysh;
                    r_cy <= r_cy + xsh;
                    r_cz <= r_cz - at;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            swk_pkg::B_CMUL: begin
                r_prod <= NW'(i_cfg.full_scale * r_sp);
                r_cmd  <= (r_sp != '0) ? 16'(swk_pkg::CMD_MAX) : 16'd0;
            end
            swk_pkg::B_CDIV: begin
                if (div_done) begin
                    r_cmd <= (div_q > NW'(swk_pkg::CMD_MAX)) ? 16'(swk_pkg::CMD_MAX)
                                                            : div_q[15:0];
                end
            end
            swk_pkg::B_OUT: if (out_load) r_w <= r_w + 1'b1;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == swk_pkg::B_OUT && out_load) begin
            r_out_valid     <= 1'b1;
            o_wheel_index   <= r_w;
            o_steer_angle   <= 16'(ang);
            o_speed_command <= r_cmd;
            o_was_scaled    <= r_scaled;
            o_last_wheel    <= last_w;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    swk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    swk_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == swk_pkg::B_SQRT_ST),
        .i_op    (r_sqx + r_sqy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_pop   = (r_state == swk_pkg::B_IDLE) && !i_empty;
    assign o_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== sv/swk_checker.sv =====
`default_nettype none
`include "swerve_wheel_kinematics_macros.svh"
// Port-level checks on the wheel result stream
module swk_checker #(
    parameter int NUM_WHEELS = swk_pkg::NUM_WHEELS_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    // stalled transaction holds
    `SWK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    // last flag marks the final wheel
    `SWK_ASSERT_NOW(a_last_idx, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 2'(NUM_WHEELS-1)), "last flag and wheel index disagree")
    // after the last wheel is taken the next result starts at wheel 0 or nothing shows
    `SWK_ASSERT_NEXT(a_restart, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid || (m_axis_tuser == 2'd0), "new command did not start at wheel 0")
    // heading stays within plus or minus pi
    `SWK_ASSERT_NOW(a_angle, i_clk, i_rst_n, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'sd25736) && ($signed(m_axis_tdata[15:0]) >= -16'sd25736), "steer angle out of range")
endmodule

bind swerve_wheel_kinematics swk_checker #(.NUM_WHEELS(NUM_WHEELS)) u_swk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
